FILE: rtl/delta_command_encoder_core_macros.svh
// Assertion macros shared by the delta command encoder RTL.
// Included by the top level; needs nothing else.
`ifndef DELTA_COMMAND_ENCODER_CORE_MACROS_SVH
`define DELTA_COMMAND_ENCODER_CORE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define DCE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every clock edge outside reset.
`define DCE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

FILE: rtl/dce_pkg.sv
// Package for the delta command encoder: field layout, queue sizing,
// back end state type and the status structs passed between modules.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package dce_pkg;

  localparam int NUM_WIDE    = 6;
  localparam int NUM_NARROW  = 2;
  localparam int NUM_MASK    = NUM_WIDE + NUM_NARROW;
  localparam int NUM_FIELDS  = NUM_MASK + 2;
  localparam int FLD_W       = $clog2(NUM_FIELDS);
  localparam int WIDE_IDX_W  = $clog2(NUM_WIDE);
  localparam int IN_DATA_W   = NUM_WIDE * 16 + NUM_NARROW * 8 + 16;

  // Field slots as walked by the back end, in transmit order.
  localparam logic [FLD_W-1:0] FLD_BUTTONS  = FLD_W'(NUM_WIDE);
  localparam logic [FLD_W-1:0] FLD_IMPULSE  = FLD_W'(NUM_WIDE + 1);
  localparam logic [FLD_W-1:0] FLD_DURATION = FLD_W'(NUM_WIDE + 2);
  localparam logic [FLD_W-1:0] FLD_LIGHT    = FLD_W'(NUM_WIDE + 3);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Same bit layout as the input tdata word, first field in the low bits.
  typedef struct packed {
    logic [7:0]                  light;
    logic [7:0]                  duration;
    logic [NUM_NARROW-1:0][7:0]  narrow;
    logic [NUM_WIDE-1:0][15:0]   wide;
  } cmd_t;

  typedef struct packed {
    logic [NUM_MASK-1:0] mask;
    cmd_t                cmd;
  } entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MASK,
    BK_FIELDS
  } bk_state_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } q_stat_t;

  typedef struct packed {
    bk_state_t state;
    logic      emit;
  } bk_stat_t;

endpackage

FILE: rtl/delta_command_encoder_core.sv
// Delta command encoder, top level: front end, command queue and back end.
// Depends on dce_pkg, dce_front, dce_queue, dce_back and the macro header.
//
// Usage:
//   The in_ stream carries one movement command per transfer; in_tuser is the
//   first-of-packet flag, which compares against an all-zero baseline.
//   The out_ stream carries the encoding one byte per transfer: the change
//   mask, each changed field (16-bit fields low byte first), then duration
//   and light level; out_tlast marks the final byte. A command gives 3 to 17
//   bytes.
//   Path: an accepted command is written into the queue, loaded by the back
//   end in BK_IDLE and its mask byte registered into the output in BK_MASK.
//   The back-end sequencer sets the rate: one byte per cycle while the
//   receiver is ready, plus a load step in BK_IDLE between commands.
//   The queue holds two commands, so the input keeps accepting while a
//   stalled receiver holds the registered output byte; once the queue is
//   full, in_tready drops until the back end takes the next command.
//   Reset (rst_n low, synchronous) empties the queue, clears the output and
//   sets the stored previous command to all zero.
`timescale 1ns / 1ps
`include "delta_command_encoder_core_macros.svh"

module delta_command_encoder_core
  import dce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // from bit 0: angle_pitch, angle_yaw, angle_roll, move_forward, move_side,
  // move_up (16 bits each), button_bits, impulse_code, duration_ms,
  // light_level (8 bits each)
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,   // first_of_packet
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // out_byte
  output logic                 out_tlast   // last_byte
);

  logic     push_valid;
  logic     push_ready;
  entry_t   push_entry;
  logic     head_valid;
  entry_t   head_entry;
  logic     pop;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;

  dce_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  dce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head_entry (head_entry),
    .stat       (q_stat)
  );

  dce_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .stat       (bk_stat)
  );

  `DCE_ASSERT_IMP(a_pop_not_empty, clk, rst_n, pop, !q_stat.empty, "pop from empty queue")
  `DCE_ASSERT_IMP(a_accept_has_room, clk, rst_n, in_tvalid && in_tready, !q_stat.full,
                  "command accepted into a full queue")
  `DCE_ASSERT_ALWAYS(a_count_bound, clk, rst_n, q_stat.count <= QCNT_W'(QUEUE_DEPTH),
                     "queue count beyond depth")
  `DCE_ASSERT_IMP(a_out_from_sequencer, clk, rst_n, $rose(out_tvalid),
                  $past(bk_stat.state) != BK_IDLE && $past(bk_stat.emit),
                  "output byte appeared without a sequencer transfer")

endmodule

FILE: rtl/dce_front.sv
// Front end: accepts commands, compares them with the previous command and
// builds the change mask. Depends on dce_pkg.
`timescale 1ns / 1ps

module dce_front
  import dce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output logic                 push_valid,
  input  logic                 push_ready,
  output entry_t               push_entry
);

  logic [NUM_WIDE-1:0][15:0]  prev_wide_r;
  logic [NUM_WIDE-1:0][15:0]  prev_wide_nxt;
  logic [NUM_NARROW-1:0][7:0] prev_narrow_r;
  logic [NUM_NARROW-1:0][7:0] prev_narrow_nxt;
  cmd_t                       cmd;
  logic [NUM_MASK-1:0]        mask;
  logic                       accept;

  assign cmd        = cmd_t'(in_tdata);
  assign accept     = in_tvalid & push_ready;
  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  // A first-of-packet command is compared against an all-zero baseline.
  always_comb begin
    for (int i = 0; i < NUM_WIDE; i++) begin
      mask[i] = cmd.wide[i] != (in_tuser ? 16'd0 : prev_wide_r[i]);
    end
    for (int i = 0; i < NUM_NARROW; i++) begin
      mask[NUM_WIDE + i] = cmd.narrow[i] != (in_tuser ? 8'd0 : prev_narrow_r[i]);
    end
  end

  assign push_entry = '{mask: mask, cmd: cmd};

  always_comb begin
    prev_wide_nxt   = prev_wide_r;
    prev_narrow_nxt = prev_narrow_r;
    if (accept) begin
      prev_wide_nxt   = cmd.wide;
      prev_narrow_nxt = cmd.narrow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_wide_r   <= '0;
      prev_narrow_r <= '0;
    end else begin
      prev_wide_r   <= prev_wide_nxt;
      prev_narrow_r <= prev_narrow_nxt;
    end
  end

endmodule

FILE: rtl/dce_queue.sv
// Short queue of classified commands between the front and back ends.
// Depends on dce_pkg.
`timescale 1ns / 1ps

module dce_queue
  import dce_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  entry_t  push_entry,
  output logic    head_valid,
  input  logic    pop,
  output entry_t  head_entry,
  output q_stat_t stat
);

  entry_t            slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;
  logic              full;
  logic              empty;

  assign full       = count_r == QCNT_W'(QUEUE_DEPTH);
  assign empty      = count_r == '0;
  assign push_ready = !full;
  assign head_valid = !empty;
  assign head_entry = slot_r[rd_ptr_r];
  assign do_push    = push_valid & !full;
  assign do_pop     = pop & !empty;
  assign stat       = '{count: count_r, full: full, empty: empty};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/dce_back.sv
// Back end: walks one queued command and sends its mask byte, changed
// fields and the two fixed bytes through a registered output. Depends on dce_pkg.
`timescale 1ns / 1ps

module dce_back
  import dce_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  entry_t     head_entry,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output bk_stat_t   stat
);

  bk_state_t             state_r;
  bk_state_t             state_nxt;
  logic [NUM_MASK-1:0]   mask_r;
  cmd_t                  cmd_r;
  logic [NUM_FIELDS-1:0] pend_r;
  logic [NUM_FIELDS-1:0] pend_nxt;
  logic                  hi_r;
  logic                  hi_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic [7:0]            out_data_r;
  logic                  out_last_r;
  logic [FLD_W-1:0]      sel;
  logic [7:0]            field_byte;
  logic                  out_free;
  logic                  emit;
  logic [7:0]            emit_byte;
  logic                  emit_last;
  logic                  sel_wide;

  assign out_free = !out_valid_r | out_tready;
  assign sel_wide = sel < FLD_W'(NUM_WIDE);

  // Lowest pending field goes next; duration and light are always marked pending on load.
  always_comb begin
    sel = FLD_LIGHT;
    for (int i = NUM_FIELDS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = FLD_W'(i);
      end
    end
  end

  always_comb begin
    priority if (sel_wide) begin
      field_byte = hi_r ? cmd_r.wide[sel[WIDE_IDX_W-1:0]][15:8]
                        : cmd_r.wide[sel[WIDE_IDX_W-1:0]][7:0];
    end else if (sel == FLD_BUTTONS) begin
      field_byte = cmd_r.narrow[0];
    end else if (sel == FLD_IMPULSE) begin
      field_byte = cmd_r.narrow[1];
    end else if (sel == FLD_DURATION) begin
      field_byte = cmd_r.duration;
    end else begin
      field_byte = cmd_r.light;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          state_nxt = BK_MASK;
        end
      end
      BK_MASK: begin
        if (out_free) begin
          state_nxt = BK_FIELDS;
        end
      end
      BK_FIELDS: begin
        if (out_free && sel == FLD_LIGHT) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_last = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        pop = head_valid;
      end
      BK_MASK: begin
        emit      = out_free;
        emit_byte = mask_r;
      end
      BK_FIELDS: begin
        emit      = out_free;
        emit_byte = field_byte;
        emit_last = sel == FLD_LIGHT;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // A wide field takes two transfers, low byte first, before its bit clears.
  always_comb begin
    pend_nxt = pend_r;
    hi_nxt   = hi_r;
    if (pop) begin
      pend_nxt = {{(NUM_FIELDS - NUM_MASK){1'b1}}, head_entry.mask};
      hi_nxt   = 1'b0;
    end else if (emit && state_r == BK_FIELDS) begin
      if (sel_wide && !hi_r) begin
        hi_nxt = 1'b1;
      end else begin
        hi_nxt   = 1'b0;
        pend_nxt = pend_r & ~(NUM_FIELDS'(1) << sel);
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_r      <= '0;
      hi_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      hi_r        <= hi_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mask_r <= head_entry.mask;
      cmd_r  <= head_entry.cmd;
    end
    if (emit) begin
      out_data_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign stat       = '{state: state_r, emit: emit};

endmodule
